// ===== hw/rtl/binary_factor_table_engine_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the binary factor table engine core
// Shared property forms, clocked on clock and quiet during reset.
// ---------------------------------------------------------------------------
`ifndef BINARY_FACTOR_TABLE_ENGINE_CORE_ASSERT_SVH
`define BINARY_FACTOR_TABLE_ENGINE_CORE_ASSERT_SVH

// consequence holds in the same cycle
`define BFTE_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bfte port check failed");

// consequence holds in the next cycle
`define BFTE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bfte port check failed");

`endif

// ===== hw/rtl/bfte_pkg.sv =====
// ---------------------------------------------------------------------------
// bfte_pkg
// Types, codes and constants shared by the binary factor table engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfte_pkg;

   localparam int MAX_VARS_DEF   = 10;
   localparam int MAX_VARS_LIMIT = 20;

   typedef enum logic [3:0] {
      OP_INIT     = 4'd0,
      OP_WR_ID    = 4'd1,
      OP_WR_ENTRY = 4'd2,
      OP_RD_ENTRY = 4'd3,
      OP_MARG     = 4'd4,
      OP_SCALE1   = 4'd5,
      OP_SCALE2   = 4'd6,
      OP_EVID     = 4'd7,
      OP_SUM      = 4'd8,
      OP_NORM     = 4'd9
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_RANGE     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      FPU_ADD = 2'd0,
      FPU_MUL = 2'd1,
      FPU_DIV = 2'd2
   } fpu_op_type;

   typedef struct packed {
      logic       valid;
      fpu_op_type op;
   } fpu_req_type;

   localparam logic [63:0] FP_ONE         = 64'h3FF0_0000_0000_0000;
   localparam logic [63:0] FP_ZERO        = 64'h0000_0000_0000_0000;
   localparam logic [63:0] FP_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

   typedef struct packed {
      logic [3:0]  op;
      logic [9:0]  index;
      logic [3:0]  var_count;
      logic [15:0] var_a;
      logic [15:0] var_b;
      logic [63:0] data;
      logic        evidence_bit;
   } req_item_type;

   typedef struct packed {
      logic [63:0] result_value;
      logic [1:0]  status;
      logic [3:0]  var_count_now;
   } rsp_item_type;

endpackage

// ===== hw/rtl/bfte_table_ram.sv =====
// ---------------------------------------------------------------------------
// bfte_table_ram
// Entry store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfte_table_ram #(
   parameter int AW = bfte_pkg::MAX_VARS_DEF
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [63:0]   wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [63:0]   rdata
);
   logic [63:0] mem [2**AW];
   logic [63:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== hw/rtl/bfte_fpu.sv =====
// ---------------------------------------------------------------------------
// bfte_fpu
// Multicycle binary64 add, multiply and divide, round to nearest even.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfte_fpu (
   input  logic                 clock,
   input  logic                 reset,
   input  bfte_pkg::fpu_req_type req,
   input  logic [63:0]          opa,
   input  logic [63:0]          opb,
   output logic                 done,
   output logic [63:0]          result
);
   import bfte_pkg::*;

   typedef enum logic [2:0] {
      F_IDLE, F_SPEC, F_ALIGN, F_MUL, F_DNORM, F_DIV, F_NORM, F_ROUND
   } fstate_type;

   fstate_type         state_ff;
   fpu_op_type         op_ff;
   logic [63:0]        a_ff, b_ff, result_ff;
   logic               done_ff, sign_ff, zsign_ff, sub_ff;
   logic signed [13:0] e_ff;
   logic [109:0]       m_ff, aux_ff;
   logic [10:0]        d_ff;
   logic [52:0]        sa_sig_ff, sb_sig_ff;
   logic [55:0]        q_ff;
   logic [54:0]        r_ff;
   logic [5:0]         cnt_ff;

   // operand classes
   logic [10:0]        ea, eb;
   logic               sa, sb, nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, a_ge_b;
   logic [52:0]        sig_a, sig_b;
   logic signed [13:0] exp_a, exp_b;
   logic               spec_hit;
   logic [63:0]        spec_val;

   always_comb begin
      ea     = a_ff[62:52];
      eb     = b_ff[62:52];
      sa     = a_ff[63];
      sb     = b_ff[63];
      nan_a  = (&ea) && (|a_ff[51:0]);
      nan_b  = (&eb) && (|b_ff[51:0]);
      inf_a  = (&ea) && !(|a_ff[51:0]);
      inf_b  = (&eb) && !(|b_ff[51:0]);
      zero_a = !(|a_ff[62:0]);
      zero_b = !(|b_ff[62:0]);
      sig_a  = {|ea, a_ff[51:0]};
      sig_b  = {|eb, b_ff[51:0]};
      exp_a  = (|ea) ? $signed({3'b000, ea}) : 14'sd1;
      exp_b  = (|eb) ? $signed({3'b000, eb}) : 14'sd1;
      a_ge_b = a_ff[62:0] >= b_ff[62:0];

      spec_hit = 1'b1;
      spec_val = FP_DEFAULT_NAN;
      if (nan_a) begin
         spec_val = a_ff | 64'h0008_0000_0000_0000;
      end else if (nan_b) begin
         spec_val = b_ff | 64'h0008_0000_0000_0000;
      end else begin
         case (op_ff)
            FPU_ADD: begin
               if (inf_a && inf_b && (sa != sb)) spec_val = FP_DEFAULT_NAN;
               else if (inf_a)                   spec_val = a_ff;
               else if (inf_b)                   spec_val = b_ff;
               else                              spec_hit = 1'b0;
            end
            FPU_MUL: begin
               if ((inf_a && zero_b) || (zero_a && inf_b)) spec_val = FP_DEFAULT_NAN;
               else if (inf_a || inf_b) spec_val = {sa ^ sb, 11'h7FF, 52'b0};
               else                     spec_hit = 1'b0;
            end
            default: begin
               if ((inf_a && inf_b) || (zero_a && zero_b)) spec_val = FP_DEFAULT_NAN;
               else if (inf_a || zero_b) spec_val = {sa ^ sb, 11'h7FF, 52'b0};
               else if (inf_b || zero_a) spec_val = {sa ^ sb, 63'b0};
               else                      spec_hit = 1'b0;
            end
         endcase
      end
   end

   // alignment of the smaller addend, lost bits fold into bit 0
   logic [109:0] sh_v, sum_v;
   always_comb begin
      if (d_ff > 11'd109) begin
         sh_v = {109'b0, |aux_ff};
      end else begin
         sh_v    = aux_ff >> d_ff;
         sh_v[0] = sh_v[0] | ((sh_v << d_ff) != aux_ff);
      end
      sum_v = sub_ff ? (m_ff - sh_v) : (m_ff + sh_v);
   end

   // one 27x27 partial product per cycle
   logic        hi_a, hi_b;
   logic [26:0] pa, pb;
   logic [53:0] pp;
   logic [109:0] pp_w;
   always_comb begin
      hi_a = cnt_ff[1];
      hi_b = cnt_ff[0];
      pa   = hi_a ? {1'b0, sa_sig_ff[52:27]} : sa_sig_ff[26:0];
      pb   = hi_b ? {1'b0, sb_sig_ff[52:27]} : sb_sig_ff[26:0];
      pp   = pa * pb;
      pp_w = 110'(pp) << 3;
      if (hi_a) pp_w = pp_w << 27;
      if (hi_b) pp_w = pp_w << 27;
   end

   // one quotient bit per cycle
   logic        q_bit;
   logic [54:0] r_sub, r_next;
   logic [55:0] q_next;
   always_comb begin
      q_bit  = r_ff >= {2'b00, sb_sig_ff};
      r_sub  = q_bit ? (r_ff - {2'b00, sb_sig_ff}) : r_ff;
      r_next = {r_sub[53:0], 1'b0};
      q_next = {q_ff[54:0], q_bit};
   end

   // rounding
   logic               g_bit, st_bit, inc;
   logic [53:0]        sig54;
   logic signed [13:0] exp_w;
   logic [63:0]        round_val;
   always_comb begin
      g_bit  = m_ff[54];
      st_bit = |m_ff[53:0];
      inc    = g_bit && (st_bit || m_ff[55]);
      sig54  = {1'b0, m_ff[107:55]} + 54'(inc);
      if (sig54[53])      exp_w = e_ff + 14'sd1;
      else if (sig54[52]) exp_w = e_ff;
      else                exp_w = 14'sd0;
      if (exp_w >= 14'sd2047) begin
         round_val = {sign_ff, 11'h7FF, 52'b0};
      end else begin
         round_val = {sign_ff, exp_w[10:0], sig54[53] ? 52'b0 : sig54[51:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            F_IDLE: begin
               if (req.valid) begin
                  a_ff     <= opa;
                  b_ff     <= opb;
                  op_ff    <= req.op;
                  state_ff <= F_SPEC;
               end
            end
            F_SPEC: begin
               if (spec_hit) begin
                  result_ff <= spec_val;
                  done_ff   <= 1'b1;
                  state_ff  <= F_IDLE;
               end else begin
                  case (op_ff)
                     FPU_ADD: begin
                        sign_ff  <= a_ge_b ? sa : sb;
                        zsign_ff <= sa & sb;
                        sub_ff   <= sa ^ sb;
                        e_ff     <= a_ge_b ? exp_a : exp_b;
                        m_ff     <= {2'b00, a_ge_b ? sig_a : sig_b, 55'b0};
                        aux_ff   <= {2'b00, a_ge_b ? sig_b : sig_a, 55'b0};
                        d_ff     <= a_ge_b ? 11'(exp_a - exp_b) : 11'(exp_b - exp_a);
                        state_ff <= F_ALIGN;
                     end
                     FPU_MUL: begin
                        sign_ff   <= sa ^ sb;
                        zsign_ff  <= sa ^ sb;
                        e_ff      <= exp_a + exp_b - 14'sd1023;
                        m_ff      <= '0;
                        sa_sig_ff <= sig_a;
                        sb_sig_ff <= sig_b;
                        cnt_ff    <= '0;
                        state_ff  <= F_MUL;
                     end
                     default: begin
                        sign_ff   <= sa ^ sb;
                        zsign_ff  <= sa ^ sb;
                        e_ff      <= exp_a - exp_b + 14'sd1023;
                        sa_sig_ff <= sig_a;
                        sb_sig_ff <= sig_b;
                        q_ff      <= '0;
                        state_ff  <= F_DNORM;
                     end
                  endcase
               end
            end
            F_ALIGN: begin
               m_ff     <= sum_v;
               state_ff <= F_NORM;
            end
            F_MUL: begin
               m_ff   <= m_ff + pp_w;
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd3) state_ff <= F_NORM;
            end
            F_DNORM: begin
               // bring subnormal significands up to a leading one
               if (!sa_sig_ff[52]) begin
                  sa_sig_ff <= {sa_sig_ff[51:0], 1'b0};
                  e_ff      <= e_ff - 14'sd1;
               end else if (!sb_sig_ff[52]) begin
                  sb_sig_ff <= {sb_sig_ff[51:0], 1'b0};
                  e_ff      <= e_ff + 14'sd1;
               end else begin
                  r_ff     <= {2'b00, sa_sig_ff};
                  cnt_ff   <= '0;
                  state_ff <= F_DIV;
               end
            end
            F_DIV: begin
               r_ff   <= r_next;
               q_ff   <= q_next;
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd55) begin
                  m_ff     <= {2'b00, q_next, 52'b0} | 110'(r_next != '0);
                  state_ff <= F_NORM;
               end
            end
            F_NORM: begin
               if (m_ff == '0) begin
                  result_ff <= {zsign_ff, 63'b0};
                  done_ff   <= 1'b1;
                  state_ff  <= F_IDLE;
               end else if (|m_ff[109:108]) begin
                  m_ff <= {1'b0, m_ff[109:2], m_ff[1] | m_ff[0]};
                  e_ff <= e_ff + 14'sd1;
               end else if (e_ff < 14'sd1) begin
                  if (e_ff < -14'sd120) begin
                     // far below the smallest subnormal: only sticky remains
                     m_ff <= 110'd1;
                     e_ff <= 14'sd1;
                  end else begin
                     m_ff <= {1'b0, m_ff[109:2], m_ff[1] | m_ff[0]};
                     e_ff <= e_ff + 14'sd1;
                  end
               end else if (!m_ff[107] && (e_ff > 14'sd1)) begin
                  m_ff <= {m_ff[108:0], 1'b0};
                  e_ff <= e_ff - 14'sd1;
               end else begin
                  state_ff <= F_ROUND;
               end
            end
            F_ROUND: begin
               result_ff <= round_val;
               done_ff   <= 1'b1;
               state_ff  <= F_IDLE;
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = result_ff;
endmodule

// ===== hw/rtl/binary_factor_table_engine_core.sv =====
// ---------------------------------------------------------------------------
// binary_factor_table_engine_core
// Probability table over binary variables: init, id and entry access,
// marginalize, scale, evidence, sum and normalize on binary64 entries.
// ---------------------------------------------------------------------------
//
//  channel   | ports                   | handshake
//  ----------+-------------------------+-----------------------------------
//  request   | start, busy, req_item   | taken when start high, busy low
//  response  | rsp_valid, rsp_item     | one-cycle strobe, always taken
//
// Id and entry writes and early errors answer from decode; an entry read waits
// on the registered RAM read; init writes every entry; a walk steps through the
// entries, evidence and scale misses without the FPU, marginalize reading a
// pair; FPU add, multiply and divide are multicycle; normalize walks twice.
// Reset clears control and the count; the table waits for an init fill, with no
// clearing pass. The response side never stalls; busy drops in the strobe cycle.
`timescale 1ns / 1ps

module binary_factor_table_engine_core #(
   parameter int MAX_VARS = bfte_pkg::MAX_VARS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  bfte_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   output bfte_pkg::rsp_item_type rsp_item
);
   import bfte_pkg::*;

   localparam int AW  = MAX_VARS;
   localparam int CW  = $clog2(MAX_VARS + 1);
   localparam int PW  = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
   localparam int IXW = (AW + 1 > 10) ? AW + 1 : 10;

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_FILL, S_RD_WAIT, S_WALK, S_GET_A, S_CALC, S_FPU_WAIT
   } state_type;

   state_type    state_ff;
   req_item_type req_ff;
   rsp_item_type rsp_ff;
   logic         rsp_valid_ff;
   logic [CW-1:0] count_ff;
   logic [15:0]  ids_ff [MAX_VARS];
   logic [AW:0]  idx_ff, lim_ff;
   logic [AW-1:0] mask_ff;
   logic [63:0]  acc_ff, opa_ff;
   logic         div_pass_ff;

   op_type       op;
   assign op = op_type'(req_ff.op);

   // variable lookup: lowest active position wins
   logic          found_a, found_b;
   logic [PW-1:0] loc_a, loc_b;
   always_comb begin
      found_a = 1'b0;
      found_b = 1'b0;
      loc_a   = '0;
      loc_b   = '0;
      for (int k = MAX_VARS - 1; k >= 0; k--) begin
         if ((CW'(k) < count_ff) && (ids_ff[k] == req_ff.var_a)) begin
            found_a = 1'b1;
            loc_a   = PW'(k);
         end
         if ((CW'(k) < count_ff) && (ids_ff[k] == req_ff.var_b)) begin
            found_b = 1'b1;
            loc_b   = PW'(k);
         end
      end
   end

   logic [AW:0]   tlen;
   logic          index_ok, id_pos_ok, init_ok;
   logic [AW-1:0] lowmask, src, j_lo, bit_a, bit_b;
   logic          walk_end, scale_hit, ev_clash, acc_phase;
   always_comb begin
      tlen      = (AW + 1)'(1) << count_ff;
      index_ok  = IXW'(req_ff.index) < IXW'(tlen);
      id_pos_ok = (11'(req_ff.index) < 11'(count_ff))
                  && (11'(req_ff.index) < 11'(MAX_VARS));
      init_ok   = 6'(req_ff.var_count) <= 6'(MAX_VARS);
      bit_a     = AW'(1) << loc_a;
      bit_b     = AW'(1) << loc_b;
      j_lo      = idx_ff[AW-1:0];
      lowmask   = mask_ff - AW'(1);
      // source of pair j: insert a zero at the removed position
      src       = ((j_lo & ~lowmask) << 1) | (j_lo & lowmask);
      walk_end  = idx_ff == lim_ff;
      scale_hit = (j_lo & mask_ff) == mask_ff;
      ev_clash  = ((j_lo & mask_ff) != '0) != req_ff.evidence_bit;
      acc_phase = (op == OP_SUM) || ((op == OP_NORM) && !div_pass_ff);
   end

   // table RAM and FPU hookup
   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [63:0]   ram_wdata, ram_rdata;
   fpu_req_type   fpu_req;
   logic [63:0]   fpu_a, fpu_b, fpu_result;
   logic          fpu_done;

   always_comb begin
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_waddr = j_lo;
      ram_raddr = j_lo;
      ram_wdata = FP_ZERO;
      fpu_req.valid = 1'b0;
      fpu_req.op    = FPU_ADD;
      fpu_a = acc_ff;
      fpu_b = ram_rdata;
      case (state_ff)
         S_DECODE: begin
            ram_waddr = AW'(req_ff.index);
            ram_raddr = AW'(req_ff.index);
            ram_wdata = req_ff.data;
            ram_we    = (op == OP_WR_ENTRY) && index_ok;
            ram_re    = (op == OP_RD_ENTRY) && index_ok;
         end
         S_FILL: begin
            ram_we    = 1'b1;
            ram_wdata = FP_ONE;
         end
         S_WALK: begin
            if (!walk_end) begin
               case (op)
                  OP_MARG: begin
                     ram_re    = 1'b1;
                     ram_raddr = src;
                  end
                  OP_SCALE1, OP_SCALE2: ram_re = scale_hit;
                  OP_EVID:              ram_we = ev_clash;
                  default:              ram_re = 1'b1;
               endcase
            end
         end
         S_GET_A: begin
            ram_re    = 1'b1;
            ram_raddr = src | mask_ff;
         end
         S_CALC: begin
            fpu_req.valid = 1'b1;
            case (op)
               OP_MARG: begin
                  fpu_a = opa_ff;
               end
               OP_SCALE1, OP_SCALE2: begin
                  fpu_req.op = FPU_MUL;
                  fpu_a      = ram_rdata;
                  fpu_b      = req_ff.data;
               end
               default: begin
                  if (!acc_phase) begin
                     fpu_req.op = FPU_DIV;
                     fpu_a      = ram_rdata;
                     fpu_b      = acc_ff;
                  end
               end
            endcase
         end
         S_FPU_WAIT: begin
            ram_we    = fpu_done && !acc_phase;
            ram_wdata = fpu_result;
         end
         default: ;
      endcase
   end

   bfte_table_ram #(.AW(AW)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   bfte_fpu u_fpu (
      .clock  (clock),
      .reset  (reset),
      .req    (fpu_req),
      .opa    (fpu_a),
      .opb    (fpu_b),
      .done   (fpu_done),
      .result (fpu_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff   <= req_item;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               // default answer: ok, nothing to report, count unchanged
               rsp_ff.result_value  <= FP_ZERO;
               rsp_ff.status        <= ST_OK;
               rsp_ff.var_count_now <= 4'(count_ff);
               idx_ff      <= '0;
               lim_ff      <= tlen;
               div_pass_ff <= 1'b0;
               acc_ff      <= FP_ZERO;
               state_ff    <= S_WALK;
               unique case (op)
                  OP_INIT: begin
                     if (init_ok) begin
                        count_ff             <= CW'(req_ff.var_count);
                        lim_ff               <= (AW + 1)'(1) << req_ff.var_count;
                        rsp_ff.var_count_now <= req_ff.var_count;
                        state_ff             <= S_FILL;
                     end else begin
                        rsp_ff.status <= ST_RANGE;
                        rsp_valid_ff  <= 1'b1;
                        state_ff      <= S_IDLE;
                     end
                  end
                  OP_WR_ID: begin
                     if (id_pos_ok) ids_ff[req_ff.index[PW-1:0]] <= req_ff.var_a;
                     else           rsp_ff.status <= ST_RANGE;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end
                  OP_WR_ENTRY: begin
                     if (!index_ok) rsp_ff.status <= ST_RANGE;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end
                  OP_RD_ENTRY: begin
                     if (index_ok) begin
                        state_ff <= S_RD_WAIT;
                     end else begin
                        rsp_ff.status <= ST_RANGE;
                        rsp_valid_ff  <= 1'b1;
                        state_ff      <= S_IDLE;
                     end
                  end
                  OP_MARG, OP_SCALE1, OP_EVID: begin
                     mask_ff <= bit_a;
                     if (op == OP_MARG) lim_ff <= tlen >> 1;
                     if (!found_a) begin
                        rsp_ff.status <= ST_NOT_FOUND;
                        rsp_valid_ff  <= 1'b1;
                        state_ff      <= S_IDLE;
                     end
                  end
                  OP_SCALE2: begin
                     mask_ff <= bit_a | bit_b;
                     if (!(found_a && found_b)) begin
                        rsp_ff.status <= ST_NOT_FOUND;
                        rsp_valid_ff  <= 1'b1;
                        state_ff      <= S_IDLE;
                     end
                  end
                  OP_SUM, OP_NORM: ;
                  default: begin
                     rsp_ff.status <= ST_RANGE;
                     rsp_valid_ff  <= 1'b1;
                     state_ff      <= S_IDLE;
                  end
               endcase
            end
            S_FILL: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff + 1'b1 == lim_ff) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            S_RD_WAIT: begin
               rsp_ff.result_value <= ram_rdata;
               rsp_valid_ff        <= 1'b1;
               state_ff            <= S_IDLE;
            end
            S_WALK: begin
               if (walk_end) begin
                  // finish the pass
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
                  case (op)
                     OP_MARG: begin
                        for (int k = 0; k + 1 < MAX_VARS; k++) begin
                           if ((AW'(k) >= mask_ff ? 1'b0 : 1'b0)
                               || (((AW'(1) << k) & ~lowmask) != '0
                                   && (CW'(k + 1) < count_ff))) begin
                              ids_ff[k] <= ids_ff[k + 1];
                           end
                        end
                        count_ff             <= count_ff - 1'b1;
                        rsp_ff.var_count_now <= 4'(count_ff - 1'b1);
                     end
                     OP_SUM: rsp_ff.result_value <= acc_ff;
                     OP_NORM: begin
                        if (!div_pass_ff) begin
                           if (acc_ff[62:0] == '0) begin
                              rsp_ff.status <= ST_RANGE;
                           end else begin
                              // second pass: divide each entry by the total
                              rsp_valid_ff <= 1'b0;
                              state_ff     <= S_WALK;
                              div_pass_ff  <= 1'b1;
                              idx_ff       <= '0;
                           end
                        end
                     end
                     default: ;
                  endcase
               end else begin
                  case (op)
                     OP_MARG: state_ff <= S_GET_A;
                     OP_SCALE1, OP_SCALE2: begin
                        if (scale_hit) state_ff <= S_CALC;
                        else           idx_ff   <= idx_ff + 1'b1;
                     end
                     OP_EVID: idx_ff <= idx_ff + 1'b1;
                     default: state_ff <= S_CALC;
                  endcase
               end
            end
            S_GET_A: begin
               opa_ff   <= ram_rdata;
               state_ff <= S_CALC;
            end
            S_CALC: begin
               state_ff <= S_FPU_WAIT;
            end
            S_FPU_WAIT: begin
               if (fpu_done) begin
                  if (acc_phase) acc_ff <= fpu_result;
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_WALK;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
endmodule

// ===== hw/rtl/bfte_checker.sv =====
// ---------------------------------------------------------------------------
// bfte_checker
// Port-level checks on the engine core, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "binary_factor_table_engine_core_assert.svh"

module bfte_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input bfte_pkg::rsp_item_type rsp_item
);
   import bfte_pkg::*;

   // an accepted item holds the block busy
   `BFTE_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   // a response closes the item and frees the block at once
   `BFTE_ASSERT_NOW(a_rsp_frees, rsp_valid, !busy && $past(busy))
   // no two responses back to back
   `BFTE_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid)
   // status is one of the defined codes
   `BFTE_ASSERT_NOW(a_status_code, rsp_valid,
      rsp_item.status == ST_OK || rsp_item.status == ST_NOT_FOUND
      || rsp_item.status == ST_RANGE)
endmodule

bind binary_factor_table_engine_core bfte_checker u_bfte_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

// ===== test/bfte_scoreboard.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bfte_scoreboard
// Watches both channels of the factor table engine. It keeps its own copy of
// the table, ids and count, computes each answer, and compares it per field.
// ---------------------------------------------------------------------------

module bfte_scoreboard (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  bfte_pkg::req_item_type req_item,
   input  logic                   rsp_valid,
   input  bfte_pkg::rsp_item_type rsp_item,
   output int                     fail_count,
   output int                     pending
);
   import bfte_pkg::*;

   localparam int NVARS = MAX_VARS_DEF;

   logic [15:0]  var_ids [NVARS];
   int           var_total;
   real          probs [1 << NVARS];
   rsp_item_type answer_q [$];

   function automatic int find_var(input logic [15:0] id);
      for (int i = 0; i < var_total; i++)
         if (var_ids[i] == id) return i;
      return -1;
   endfunction

   function automatic real table_total();
      real s;
      s = 0.0;
      for (int i = 0; i < (1 << var_total); i++) s = s + probs[i];
      return s;
   endfunction

   function automatic void scale_where(input int mask, input real m);
      for (int i = 0; i < (1 << var_total); i++)
         if ((i & mask) == mask) probs[i] = probs[i] * m;
   endfunction

   // Apply one item to the local copy and return the answer it should give.
   function automatic rsp_item_type apply_op(input req_item_type it);
      rsp_item_type r;
      int           pa, pb, len, src, bitv;
      real          s;
      r        = '0;
      r.status = ST_OK;
      len      = 1 << var_total;
      case (it.op)
         OP_INIT: begin
            if (it.var_count > NVARS) r.status = ST_RANGE;
            else begin
               var_total = int'(it.var_count);
               for (int i = 0; i < (1 << var_total); i++) probs[i] = 1.0;
            end
         end
         OP_WR_ID: begin
            if (it.index >= var_total) r.status = ST_RANGE;
            else var_ids[it.index] = it.var_a;
         end
         OP_WR_ENTRY: begin
            if (it.index >= len) r.status = ST_RANGE;
            else probs[it.index] = $bitstoreal(it.data);
         end
         OP_RD_ENTRY: begin
            if (it.index >= len) r.status = ST_RANGE;
            else r.result_value = $realtobits(probs[it.index]);
         end
         OP_MARG: begin
            pa = find_var(it.var_a);
            if (pa < 0) r.status = ST_NOT_FOUND;
            else begin
               bitv = 1 << pa;
               // in place: the source never sits below the destination
               for (int j = 0; j < len / 2; j++) begin
                  src      = ((j >> pa) << (pa + 1)) | (j & (bitv - 1));
                  probs[j] = probs[src] + probs[src | bitv];
               end
               for (int k = pa; k + 1 < var_total; k++) var_ids[k] = var_ids[k + 1];
               var_total--;
            end
         end
         OP_SCALE1: begin
            pa = find_var(it.var_a);
            if (pa < 0) r.status = ST_NOT_FOUND;
            else scale_where(1 << pa, $bitstoreal(it.data));
         end
         OP_SCALE2: begin
            pa = find_var(it.var_a);
            pb = find_var(it.var_b);
            if (pa < 0 || pb < 0) r.status = ST_NOT_FOUND;
            else scale_where((1 << pa) | (1 << pb), $bitstoreal(it.data));
         end
         OP_EVID: begin
            pa = find_var(it.var_a);
            if (pa < 0) r.status = ST_NOT_FOUND;
            else
               for (int i = 0; i < len; i++)
                  if (((i >> pa) & 1) != it.evidence_bit) probs[i] = 0.0;
         end
         OP_SUM: r.result_value = $realtobits(table_total());
         OP_NORM: begin
            s = table_total();
            if (s == 0.0) r.status = ST_RANGE;
            else for (int i = 0; i < len; i++) probs[i] = probs[i] / s;
         end
         default: r.status = ST_RANGE;
      endcase
      r.var_count_now = 4'(var_total);
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         var_total  = 0;
         fail_count <= 0;
         pending    <= 0;
         answer_q.delete();
      end else begin
         // compare first: an answer and a new item may share one edge
         if (rsp_valid) begin
            if (answer_q.size() == 0) begin
               $error("response with nothing outstanding");
               fail_count <= fail_count + 1;
            end else begin
               want = answer_q.pop_front();
               if (rsp_item.result_value !== want.result_value) begin
                  $error("result_value: expected %h, got %h",
                         want.result_value, rsp_item.result_value);
                  fail_count <= fail_count + 1;
               end
               if (rsp_item.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_item.status);
                  fail_count <= fail_count + 1;
               end
               if (rsp_item.var_count_now !== want.var_count_now) begin
                  $error("var_count_now: expected %0d, got %0d",
                         want.var_count_now, rsp_item.var_count_now);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy) answer_q.insert(answer_q.size(), apply_op(req_item));
         pending <= answer_q.size();
      end
   end

endmodule

// ===== test/tb_binary_factor_table_engine_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_binary_factor_table_engine_core
// Drives the factor table engine with a directed opening and then random
// sessions (init, id writes, table ops, noise); the scoreboard checks answers.
// ---------------------------------------------------------------------------

module tb_binary_factor_table_engine_core;
   import bfte_pkg::*;

   localparam int ITEM_GOAL   = 290;
   localparam int CYCLE_LIMIT = 200000000;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_valid;
   rsp_item_type rsp_item;
   int           fail_count;
   int           pending;

   int           cycle_count;
   int           items_sent;
   int           burst_left;
   // stimulus-side view of the variable list, used to aim lookups
   logic [15:0]  live_ids [$];

   binary_factor_table_engine_core u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   bfte_scoreboard u_scoreboard (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("binary_factor_table_engine_core regression: fail");
         $finish;
      end
   end

   // Finite binary64 with a moderate exponent, random sign and mantissa.
   function automatic logic [63:0] rand_fp();
      logic [63:0] v;
      v[63]    = 1'($urandom_range(0, 1));
      v[62:52] = 11'($urandom_range(11'h3F0, 11'h40F));
      v[51:32] = 20'($urandom);
      v[31:0]  = $urandom;
      return v;
   endfunction

   // Random filler for every field; callers overwrite what the op uses.
   function automatic req_item_type make_item(input logic [3:0] op);
      req_item_type it;
      it.op           = op;
      it.index        = 10'($urandom);
      it.var_count    = 4'($urandom);
      it.var_a        = 16'($urandom);
      it.var_b        = 16'($urandom);
      it.data         = {$urandom, $urandom};
      it.evidence_bit = 1'($urandom);
      return it;
   endfunction

   // Hold the item until taken; drop start between bursts.
   task automatic send(input req_item_type it);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
      end
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      burst_left--;
      items_sent++;
   endtask

   // Hold off until every answer has come back.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      burst_left = $urandom_range(1, 8);
   endtask

   task automatic send_op(input logic [3:0] op, input int idx, input int va,
                          input int vb, input logic [63:0] d, input int ev);
      req_item_type it;
      it              = make_item(op);
      it.index        = 10'(idx);
      it.var_a        = 16'(va);
      it.var_b        = 16'(vb);
      it.data         = d;
      it.evidence_bit = 1'(ev);
      send(it);
   endtask

   // Init, then fill every id position so lookups never see an unwritten id.
   task automatic init_table(input int n, input bit fixed_ids);
      req_item_type it;
      logic [15:0]  id;
      it           = make_item(OP_INIT);
      it.var_count = 4'(n);
      send(it);
      if (n > MAX_VARS_DEF) return;
      live_ids.delete();
      id = 16'($urandom_range(0, 200));
      for (int k = 0; k < n; k++) begin
         if (fixed_ids) id = (k == n - 1) ? 16'hFFFF : 16'(k * 7);
         live_ids.insert(live_ids.size(), id);
         send_op(OP_WR_ID, k, id, $urandom, {$urandom, $urandom}, $urandom);
         id = 16'(id + $urandom_range(1, 9000));
         if (id < live_ids[k]) id = live_ids[k] + 16'd1;
      end
   endtask

   // Mostly a live id, sometimes a stray one to hit the not-found path.
   function automatic logic [15:0] pick_var();
      if (live_ids.size() > 0 && $urandom_range(0, 5) != 0)
         return live_ids[$urandom_range(0, live_ids.size() - 1)];
      return 16'($urandom);
   endfunction

   task automatic marginalize(input logic [15:0] va);
      send_op(OP_MARG, $urandom, va, $urandom, {$urandom, $urandom}, $urandom);
      foreach (live_ids[k])
         if (live_ids[k] == va) begin
            live_ids.delete(k);
            break;
         end
   endtask

   task automatic random_op();
      int          len;
      int          pick;
      logic [15:0] va;
      len  = 1 << live_ids.size();
      pick = $urandom_range(0, 99);
      va   = pick_var();
      if (pick < 12)
         send_op(OP_WR_ENTRY, $urandom_range(0, len - 1), $urandom, $urandom, rand_fp(), $urandom);
      else if (pick < 24)
         send_op(OP_RD_ENTRY, $urandom_range(0, len - 1), $urandom, $urandom,
                 {$urandom, $urandom}, $urandom);
      else if (pick < 32)
         marginalize(va);
      else if (pick < 46)
         send_op(OP_SCALE1, $urandom, va, $urandom, rand_fp(), $urandom);
      else if (pick < 60)
         send_op(OP_SCALE2, $urandom, va, pick_var(), rand_fp(), $urandom);
      else if (pick < 68)
         send_op(OP_EVID, $urandom, va, $urandom, {$urandom, $urandom}, $urandom);
      else if (pick < 78)
         send_op(OP_SUM, $urandom, $urandom, $urandom, {$urandom, $urandom}, $urandom);
      else if (pick < 88)
         send_op(OP_NORM, $urandom, $urandom, $urandom, {$urandom, $urandom}, $urandom);
      else if (pick < 92)
         send(make_item(4'($urandom_range(10, 15))));
      else if (pick < 96)
         send_op(OP_WR_ID, $urandom_range(live_ids.size(), 1023), $urandom, $urandom,
                 {$urandom, $urandom}, $urandom);
      else
         send_op($urandom_range(0, 1) ? OP_RD_ENTRY : OP_WR_ENTRY,
                 $urandom_range(len, 1023), $urandom, $urandom, rand_fp(), $urandom);
   endtask

   initial begin
      int n;
      cycle_count = 0;
      items_sent  = 0;
      burst_left  = 4;
      reset       = 1'b1;
      start       = 1'b0;
      req_item    = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: range errors, the largest table, every op, the edge cases.
      init_table(11, 0);
      init_table(10, 1);
      send_op(OP_RD_ENTRY, 1023, 0, 0, 0, 0);
      send_op(OP_SCALE1, 0, 16'hFFFF, 0, 64'h3FE0_0000_0000_0000, 0);
      send_op(OP_SCALE2, 0, 16'h0000, 16'hFFFF, 64'hC000_0000_0000_0000, 0);
      send_op(OP_SCALE2, 0, 16'h0007, 16'h0007, 64'h4008_0000_0000_0000, 0);
      send_op(OP_SCALE2, 0, 16'h0007, 16'h1234, 64'h4008_0000_0000_0000, 0);
      send_op(OP_EVID, 0, 16'h000E, 0, 0, 1);
      marginalize(16'hFFFF);
      marginalize(16'h4321);
      send_op(OP_SUM, 0, 0, 0, 0, 0);
      send_op(OP_NORM, 0, 0, 0, 0, 0);
      send_op(OP_WR_ID, 9, 16'h5555, 0, 0, 0);
      send(make_item(4'd12));
      send(make_item(4'd15));
      drain();
      init_table(0, 0);
      send_op(OP_WR_ENTRY, 0, 0, 0, 64'h8000_0000_0000_0000, 0);
      send_op(OP_NORM, 0, 0, 0, 0, 0);
      init_table(3, 0);
      send_op(OP_WR_ENTRY, 7, 0, 0, 64'h7FEF_FFFF_FFFF_FFFF, 0);
      send_op(OP_RD_ENTRY, 7, 0, 0, 0, 0);
      send_op(OP_RD_ENTRY, 8, 0, 0, 0, 0);
      send_op(OP_EVID, 0, live_ids[0], 0, 0, 0);
      send_op(OP_SUM, 0, 0, 0, 0, 0);
      drain();

      // Random sessions: a well-formed setup, then a run of random ops.
      while (items_sent < ITEM_GOAL) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 15) : $urandom_range(0, 6);
         init_table(n, 0);
         repeat ($urandom_range(6, 20)) random_op();
         if ($urandom_range(0, 4) == 0) drain();
      end

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("binary_factor_table_engine_core regression: pass");
      end else begin
         $display("binary_factor_table_engine_core regression: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/bfte_pkg.sv
hw/rtl/bfte_table_ram.sv
hw/rtl/bfte_fpu.sv
hw/rtl/binary_factor_table_engine_core.sv
hw/rtl/bfte_checker.sv
test/bfte_scoreboard.sv
test/tb_binary_factor_table_engine_core.sv
